@@ hw/rtl/packed_pixel_masked_blit_unit_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the packed pixel masked blit unit
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef PACKED_PIXEL_MASKED_BLIT_UNIT_ASSERT_SVH
`define PACKED_PIXEL_MASKED_BLIT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define PPMB_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);
`define PPMB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg) \
	lbl: assert property (@(posedge clk_sig) prop) else $error(msg);
`else
`define PPMB_ASSERT(lbl, clk_sig, rst_n_sig, prop, msg)
`define PPMB_ASSERT_ALWAYS(lbl, clk_sig, prop, msg)
`endif

`endif

@@ hw/rtl/ppmb_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed pixel masked blit package
// Word layouts, register indexes, depth codes and the depth code helper.
// ----------------------------------------------------------------------------
`default_nettype none

package ppmb_pkg;

	localparam int WORD_BITS      = 32;
	localparam int OFFSET_BITS    = $clog2(WORD_BITS);
	localparam int BPP_BITS       = 4;
	localparam int KEY_BITS       = 8;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 8;

	localparam logic [CFG_INDEX_BITS-1:0] REG_BITS_PER_PIXEL  = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_ENABLE      = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY_COLOUR      = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BIT_OFFSET = 2'd3;

	localparam logic [1:0] DEPTH_1 = 2'd0;
	localparam logic [1:0] DEPTH_2 = 2'd1;
	localparam logic [1:0] DEPTH_4 = 2'd2;
	localparam logic [1:0] DEPTH_8 = 2'd3;

	typedef struct packed {
		logic [WORD_BITS-1:0] sprite_word;
		logic [WORD_BITS-1:0] edge_mask;
		logic [WORD_BITS-1:0] dest_word_a;
		logic [WORD_BITS-1:0] dest_word_b;
		logic                 write_a;
		logic                 write_b;
		logic                 blit_start;
	} in_word_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] new_word_a;
		logic [WORD_BITS-1:0] new_word_b;
		logic                 word_hit;
		logic                 blit_collision;
	} out_word_t;

	typedef struct packed {
		logic [1:0]             depth_sel;
		logic                   key_enable;
		logic [KEY_BITS-1:0]    key_colour;
		logic [OFFSET_BITS-1:0] dest_bit_offset;
	} blit_cfg_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] new_word_a;
		logic [WORD_BITS-1:0] new_word_b;
		logic                 word_hit;
	} merge_res_t;

	// Depth values other than 1, 2, 4 and 8 round down; zero acts as one.
	function automatic logic [1:0] depth_code(input logic [BPP_BITS-1:0] bpp);
		logic [1:0] code;
		if (bpp >= 4'd8) begin
			code = DEPTH_8;
		end else if (bpp >= 4'd4) begin
			code = DEPTH_4;
		end else if (bpp >= 4'd2) begin
			code = DEPTH_2;
		end else begin
			code = DEPTH_1;
		end
		return code;
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ppmb_merge.sv @@
// ----------------------------------------------------------------------------
// Packed pixel masked blit merge
// Builds the opacity mask, shifts the masked sprite and merges both words.
// ----------------------------------------------------------------------------
`default_nettype none

module ppmb_merge (
	input  ppmb_pkg::in_word_t   word,
	input  ppmb_pkg::blit_cfg_t  cfg,
	output ppmb_pkg::merge_res_t res
);
	import ppmb_pkg::*;

	logic [WORD_BITS-1:0]   key_rep1, key_rep2, key_rep4, key_rep8;
	logic [WORD_BITS-1:0]   diff1, diff2, diff4, diff8;
	logic [WORD_BITS-1:0]   mask2, mask4, mask8;
	logic [WORD_BITS-1:0]   key_mask;
	logic [WORD_BITS-1:0]   mask;
	logic [WORD_BITS-1:0]   spr;
	logic [2*WORD_BITS-1:0] mask_wide;
	logic [2*WORD_BITS-1:0] spr_wide;
	logic [WORD_BITS-1:0]   m_a, m_b;
	logic                   hit_a, hit_b;

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			key_rep1[i] = cfg.key_colour[0];
			key_rep2[i] = cfg.key_colour[i % 2];
			key_rep4[i] = cfg.key_colour[i % 4];
			key_rep8[i] = cfg.key_colour[i % 8];
		end
		diff1 = (word.sprite_word ^ key_rep1) & word.edge_mask;
		diff2 = (word.sprite_word ^ key_rep2) & word.edge_mask;
		diff4 = (word.sprite_word ^ key_rep4) & word.edge_mask;
		diff8 = (word.sprite_word ^ key_rep8) & word.edge_mask;
		for (int p = 0; p < WORD_BITS / 2; p++) begin
			mask2[2*p +: 2] = {2{|diff2[2*p +: 2]}};
		end
		for (int p = 0; p < WORD_BITS / 4; p++) begin
			mask4[4*p +: 4] = {4{|diff4[4*p +: 4]}};
		end
		for (int p = 0; p < WORD_BITS / 8; p++) begin
			mask8[8*p +: 8] = {8{|diff8[8*p +: 8]}};
		end
	end

	always_comb begin
		case (cfg.depth_sel)
			DEPTH_1: key_mask = diff1;
			DEPTH_2: key_mask = mask2;
			DEPTH_4: key_mask = mask4;
			DEPTH_8: key_mask = mask8;
			default: key_mask = diff1;
		endcase
	end

	// The upper half of each wide value lands in word a, the lower half in word b.
	assign mask      = cfg.key_enable ? key_mask : word.edge_mask;
	assign spr       = word.sprite_word & mask;
	assign mask_wide = {mask, {WORD_BITS{1'b0}}} >> cfg.dest_bit_offset;
	assign spr_wide  = {spr, {WORD_BITS{1'b0}}} >> cfg.dest_bit_offset;
	assign m_a       = mask_wide[2*WORD_BITS-1:WORD_BITS];
	assign m_b       = mask_wide[WORD_BITS-1:0];

	assign hit_a = word.write_a & (|(word.dest_word_a & m_a));
	assign hit_b = word.write_b & (|(word.dest_word_b & m_b));

	assign res.new_word_a = word.write_a ?
		((word.dest_word_a & ~m_a) | spr_wide[2*WORD_BITS-1:WORD_BITS]) : word.dest_word_a;
	assign res.new_word_b = word.write_b ?
		((word.dest_word_b & ~m_b) | spr_wide[WORD_BITS-1:0]) : word.dest_word_b;
	assign res.word_hit   = hit_a | hit_b;

endmodule

`default_nettype wire

@@ hw/rtl/packed_pixel_masked_blit_unit.sv @@
// ----------------------------------------------------------------------------
// Packed pixel masked blit unit
// Masked, color keyed merge of one sprite word into two background words.
// ----------------------------------------------------------------------------
// The unit takes one word per cycle while the output is not stalled and returns
// one result word per input word. Each word is held in the input register and
// then in the result register, with the mask, shift and merge logic in between.
// The sticky collision flag is updated as each word leaves the input register,
// so results come out in order and a stall on the output only holds the pipe.
`default_nettype none

`include "packed_pixel_masked_blit_unit_assert.svh"

module packed_pixel_masked_blit_unit (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	output logic                                in_ready,
	input  ppmb_pkg::in_word_t                  in_data,
	output logic                                out_valid,
	input  wire                                 out_ready,
	output ppmb_pkg::out_word_t                 out_data,
	input  wire                                 cfg_we,
	input  wire [ppmb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire [ppmb_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import ppmb_pkg::*;

	logic [BPP_BITS-1:0]    bits_per_pixel_q;
	logic                   key_enable_q;
	logic [KEY_BITS-1:0]    key_colour_q;
	logic [OFFSET_BITS-1:0] dest_bit_offset_q;
	logic                   collision_seen_q;

	logic       valid_s1;
	in_word_t   data_s1;
	logic       valid_s2;
	out_word_t  data_s2;

	blit_cfg_t  cfg;
	merge_res_t res;
	logic       adv_s2;
	logic       move_s2;
	logic       collision_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_per_pixel_q  <= BPP_BITS'(2);
			key_enable_q      <= 1'b0;
			key_colour_q      <= '0;
			dest_bit_offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BITS_PER_PIXEL:  bits_per_pixel_q  <= cfg_data[BPP_BITS-1:0];
				REG_KEY_ENABLE:      key_enable_q      <= cfg_data[0];
				REG_KEY_COLOUR:      key_colour_q      <= cfg_data[KEY_BITS-1:0];
				REG_DEST_BIT_OFFSET: dest_bit_offset_q <= cfg_data[OFFSET_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.depth_sel       = depth_code(bits_per_pixel_q);
	assign cfg.key_enable      = key_enable_q;
	assign cfg.key_colour      = key_colour_q;
	assign cfg.dest_bit_offset = dest_bit_offset_q;

	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;
	assign move_s2  = valid_s1 && adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= in_data;
		end
	end

	ppmb_merge u_merge (
		.word (data_s1),
		.cfg  (cfg),
		.res  (res)
	);

	assign collision_next = (collision_seen_q && !data_s1.blit_start) || res.word_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2         <= 1'b0;
			collision_seen_q <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s2) begin
				collision_seen_q <= collision_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2) begin
			data_s2.new_word_a     <= res.new_word_a;
			data_s2.new_word_b     <= res.new_word_b;
			data_s2.word_hit       <= res.word_hit;
			data_s2.blit_collision <= collision_next;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

	`PPMB_ASSERT(a_hit_sets_collision, clk, arst_n, out_valid && out_data.word_hit |-> out_data.blit_collision, "word hit without collision flag")
	`PPMB_ASSERT(a_collision_rise_has_hit, clk, arst_n, $rose(collision_seen_q) |-> $past(move_s2 && res.word_hit), "collision flag set without a hit")
	`PPMB_ASSERT(a_empty_input_ready, clk, arst_n, !valid_s1 |-> in_ready, "empty input register not ready")
	`PPMB_ASSERT_ALWAYS(a_reset_clears_valid, clk, !arst_n |-> !valid_s1 && !valid_s2, "valid set during reset")

endmodule

`default_nettype wire

@@ tb/ppmb_blit_checker.sv @@
// ----------------------------------------------------------------------------
// Packed pixel masked blit checker
// Follows the register writes and the input words of the blit unit, works out
// the merged words, hit and sticky collision for each accepted word, and
// compares every result word field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ppmb_blit_checker (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 in_valid,
	input  wire                                 in_ready,
	input  ppmb_pkg::in_word_t                  in_data,
	input  wire                                 out_valid,
	input  wire                                 out_ready,
	input  ppmb_pkg::out_word_t                 out_data,
	input  wire                                 cfg_we,
	input  wire [ppmb_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire [ppmb_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	output int                                  mismatch_count,
	output int                                  merges_pending
);
	import ppmb_pkg::*;

	logic [BPP_BITS-1:0]    bpp_reg;
	logic                   key_on_reg;
	logic [KEY_BITS-1:0]    key_reg;
	logic [OFFSET_BITS-1:0] offset_reg;
	logic                   collision_seen;
	out_word_t              expected_merges[$];
	out_word_t              want;

	task automatic report_mismatch(input string what, input logic [WORD_BITS-1:0] got,
			input logic [WORD_BITS-1:0] exp_val);
		$display("mismatch in %s: got %h, expected %h", what, got, exp_val);
		mismatch_count++;
	endtask

	function automatic out_word_t predict_merge(input in_word_t w);
		out_word_t             res;
		int                    depth;
		int                    shift;
		logic [WORD_BITS-1:0]  pix;
		logic [WORD_BITS-1:0]  key;
		logic [WORD_BITS-1:0]  opaque;
		logic [WORD_BITS-1:0]  spr;
		logic [WORD_BITS-1:0]  ma;
		logic [WORD_BITS-1:0]  mb;
		logic                  hit;
		if (bpp_reg >= 8) begin
			depth = 8;
		end else if (bpp_reg >= 4) begin
			depth = 4;
		end else if (bpp_reg >= 2) begin
			depth = 2;
		end else begin
			depth = 1;
		end
		shift = int'(offset_reg) % WORD_BITS;
		pix = (WORD_BITS'(1) << depth) - WORD_BITS'(1);
		key = WORD_BITS'(key_reg) & pix;
		if (key_on_reg) begin
			opaque = '0;
			for (int pos = 0; pos < WORD_BITS; pos += depth) begin
				if ((((w.sprite_word >> pos) ^ key) & (w.edge_mask >> pos) & pix) != '0) begin
					opaque |= pix << pos;
				end
			end
		end else begin
			opaque = w.edge_mask;
		end
		spr = w.sprite_word & opaque;
		hit = 1'b0;
		res.new_word_a = w.dest_word_a;
		res.new_word_b = w.dest_word_b;
		if (w.write_a) begin
			ma = opaque >> shift;
			if ((w.dest_word_a & ma) != '0) begin
				hit = 1'b1;
			end
			res.new_word_a = (w.dest_word_a & ~ma) | (spr >> shift);
		end
		if (w.write_b && shift != 0) begin
			mb = opaque << (WORD_BITS - shift);
			if ((w.dest_word_b & mb) != '0) begin
				hit = 1'b1;
			end
			res.new_word_b = (w.dest_word_b & ~mb) | (spr << (WORD_BITS - shift));
		end
		if (w.blit_start) begin
			collision_seen = 1'b0;
		end
		if (hit) begin
			collision_seen = 1'b1;
		end
		res.word_hit = hit;
		res.blit_collision = collision_seen;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_reg = 4'd2;
			key_on_reg = 1'b0;
			key_reg = '0;
			offset_reg = '0;
			collision_seen = 1'b0;
			expected_merges.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (expected_merges.size() == 0) begin
					report_mismatch("unexpected result word", out_data.new_word_a, '0);
				end else begin
					want = expected_merges.pop_front();
					if (out_data.new_word_a !== want.new_word_a) begin
						report_mismatch("new_word_a", out_data.new_word_a, want.new_word_a);
					end
					if (out_data.new_word_b !== want.new_word_b) begin
						report_mismatch("new_word_b", out_data.new_word_b, want.new_word_b);
					end
					if (out_data.word_hit !== want.word_hit) begin
						report_mismatch("word_hit", WORD_BITS'(out_data.word_hit),
							WORD_BITS'(want.word_hit));
					end
					if (out_data.blit_collision !== want.blit_collision) begin
						report_mismatch("blit_collision", WORD_BITS'(out_data.blit_collision),
							WORD_BITS'(want.blit_collision));
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_merges.push_back(predict_merge(in_data));
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BITS_PER_PIXEL: begin
						bpp_reg = cfg_data[BPP_BITS-1:0];
					end
					REG_KEY_ENABLE: begin
						key_on_reg = cfg_data[0];
					end
					REG_KEY_COLOUR: begin
						key_reg = cfg_data[KEY_BITS-1:0];
					end
					REG_DEST_BIT_OFFSET: begin
						offset_reg = cfg_data[OFFSET_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
		end
		merges_pending = expected_merges.size();
	end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// Packed pixel masked blit testbench
// Drives directed and random sprite words through the blit unit under many
// register settings, with random gaps on both channels, and lets the checker
// predict and compare every result word.
// ----------------------------------------------------------------------------
module tb_top;
	import ppmb_pkg::*;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	in_word_t                  in_data;
	logic                      out_valid;
	logic                      out_ready;
	out_word_t                 out_data;
	logic                      cfg_we;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	int                        mismatch_count;
	int                        merges_pending;

	logic                      steady;
	int                        pix_bits;
	logic                      key_on;
	logic [KEY_BITS-1:0]       key_val;
	logic [OFFSET_BITS-1:0]    shift;
	int                        words_sent;
	int                        settings_used;

	packed_pixel_masked_blit_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ppmb_blit_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.merges_pending (merges_pending)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#4 clk = ~clk;
		end
	end

	initial begin
		#3000000;
		$display("simulation failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= steady || ($urandom_range(99) >= 6);
		end
	end

	function automatic int depth_of_bpp(input logic [BPP_BITS-1:0] bpp);
		return (bpp >= 8) ? 8 : (bpp >= 4) ? 4 : (bpp >= 2) ? 2 : 1;
	endfunction

	function automatic in_word_t word_of(input logic [WORD_BITS-1:0] spr,
			input logic [WORD_BITS-1:0] span, input logic [WORD_BITS-1:0] da,
			input logic [WORD_BITS-1:0] db, input logic wa, input logic wb, input logic st);
		in_word_t w;
		w.sprite_word = spr;
		w.edge_mask = span;
		w.dest_word_a = da;
		w.dest_word_b = db;
		w.write_a = wa;
		w.write_b = wb;
		w.blit_start = st;
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		if (!steady && $urandom_range(99) < 3) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic set_regs(input logic [BPP_BITS-1:0] bpp, input logic ken,
			input logic [KEY_BITS-1:0] key, input logic [OFFSET_BITS-1:0] off);
		in_valid <= 1'b0;
		while (merges_pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_BITS_PER_PIXEL;
		cfg_data <= {4'($urandom), bpp};
		@(negedge clk);
		cfg_index <= REG_KEY_ENABLE;
		cfg_data <= {7'($urandom), ken};
		@(negedge clk);
		cfg_index <= REG_KEY_COLOUR;
		cfg_data <= key;
		@(negedge clk);
		cfg_index <= REG_DEST_BIT_OFFSET;
		cfg_data <= {3'($urandom), off};
		@(negedge clk);
		cfg_we <= 1'b0;
		pix_bits = depth_of_bpp(bpp);
		key_on = ken;
		key_val = key;
		shift = off;
		settings_used++;
	endtask

	// Blits are runs of words: the first carries the start flag and a left edge,
	// the last a right edge. Keyed sprites get many pixels equal to the key.
	task automatic run_blits(input int words);
		int                   sent;
		int                   len;
		logic [WORD_BITS-1:0] spr;
		logic [WORD_BITS-1:0] span;
		logic [WORD_BITS-1:0] da;
		logic [WORD_BITS-1:0] db;
		logic [WORD_BITS-1:0] pm;
		logic                 wa;
		logic                 wb;
		sent = 0;
		pm = (WORD_BITS'(1) << pix_bits) - WORD_BITS'(1);
		while (sent < words) begin
			len = $urandom_range(1, 8);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(99) < 12) begin
					send_word(word_of($urandom, $urandom, $urandom, $urandom,
						1'($urandom_range(1)), 1'($urandom_range(1)),
						1'($urandom_range(1))));
				end else begin
					spr = $urandom;
					if (key_on) begin
						for (int p = 0; p < WORD_BITS; p += pix_bits) begin
							if ($urandom_range(1)) begin
								spr = (spr & ~(pm << p)) | ((WORD_BITS'(key_val) & pm) << p);
							end
						end
					end
					span = '1;
					if (k == 0) begin
						span = span >> (pix_bits * $urandom_range(0, WORD_BITS / pix_bits - 1));
					end
					if (k == len - 1) begin
						span &= '1 << (pix_bits * $urandom_range(0, WORD_BITS / pix_bits - 1));
					end
					case ($urandom_range(2))
						0: begin
							da = '0;
							db = '0;
						end
						1: begin
							da = $urandom;
							db = $urandom;
						end
						default: begin
							da = $urandom & $urandom & $urandom;
							db = $urandom & $urandom & $urandom;
						end
					endcase
					wa = $urandom_range(9) != 0;
					wb = (shift != 0) ? ($urandom_range(9) != 0) : 1'($urandom_range(1));
					send_word(word_of(spr, span, da, db, wa, wb, k == 0));
				end
				sent++;
			end
		end
	endtask

	initial begin
		logic [BPP_BITS-1:0]    bpp;
		logic                   ken;
		logic [KEY_BITS-1:0]    key;
		logic [OFFSET_BITS-1:0] off;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = REG_BITS_PER_PIXEL;
		cfg_data = '0;
		steady = 1'b0;
		pix_bits = 2;
		key_on = 1'b0;
		key_val = '0;
		shift = '0;
		words_sent = 0;
		settings_used = 1;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: depth 2, no keying, no offset.
		send_word(word_of('0, '0, '0, '0, 1'b1, 1'b1, 1'b1));
		send_word(word_of('1, '1, '1, '1, 1'b1, 1'b1, 1'b0));
		send_word(word_of('1, '0, '1, '1, 1'b1, 1'b0, 1'b0));
		send_word(word_of('1, '1, '0, '1, 1'b1, 1'b1, 1'b1));
		send_word(word_of('1, '1, '1, '1, 1'b0, 1'b1, 1'b0));

		// Odd depth rounds down to 2; pixels with only some bits inside the edge.
		set_regs(4'd3, 1'b1, 8'h02, 5'd31);
		send_word(word_of(32'h0000_0003, 32'h0000_0001, '0, '1, 1'b1, 1'b1, 1'b1));
		send_word(word_of(32'h0000_0003, 32'h0000_0002, '1, '1, 1'b1, 1'b1, 1'b1));
		send_word(word_of(32'hAAAA_AAAA, '1, '1, '1, 1'b1, 1'b1, 1'b0));
		send_word(word_of(32'h5555_5555, '1, '1, '1, 1'b1, 1'b1, 1'b0));

		// Zero depth acts as one.
		set_regs(4'd0, 1'b1, 8'hFF, 5'd1);
		send_word(word_of('0, '1, '1, '0, 1'b1, 1'b1, 1'b1));
		send_word(word_of('1, '1, '1, '1, 1'b1, 1'b1, 1'b1));
		send_word(word_of(32'h8000_0001, '1, '1, '1, 1'b0, 1'b1, 1'b1));

		set_regs(4'd15, 1'b0, 8'h00, 5'd16);
		send_word(word_of(32'h1234_5678, 32'hFFFF_0000, '0, '0, 1'b1, 1'b1, 1'b1));
		send_word(word_of('1, '1, '1, '1, 1'b1, 1'b1, 1'b0));
		send_word(word_of('1, '1, '1, '1, 1'b0, 1'b0, 1'b1));

		set_regs(4'd8, 1'b1, 8'h00, 5'd8);
		send_word(word_of(32'h00FF_0000, '1, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, 1'b1, 1'b1));
		send_word(word_of('1, '0, '1, '1, 1'b1, 1'b1, 1'b0));

		set_regs(4'd4, 1'b1, 8'h0F, 5'd4);
		send_word(word_of(32'hF0F0_F0F0, '1, '1, '1, 1'b1, 1'b1, 1'b1));
		send_word(word_of(32'h0F0F_0F0F, 32'h0F0F_0F0F, '1, '1, 1'b1, 1'b1, 1'b0));

		for (int ph = 0; ph < 24; ph++) begin
			bpp = (ph < 16) ? 4'(ph) : 4'($urandom_range(15));
			ken = (ph < 16) ? ph[0] : 1'($urandom_range(1));
			key = (ph == 1) ? 8'h00 : (ph == 3) ? 8'hFF : 8'($urandom);
			case (ph % 4)
				0: off = '0;
				1: off = 5'd31;
				2: off = 5'((depth_of_bpp(bpp) * $urandom_range(31)) % WORD_BITS);
				default: off = 5'($urandom_range(31));
			endcase
			set_regs(bpp, ken, key, off);
			steady = (ph >= 10 && ph < 13);
			run_blits(50);
		end
		steady = 1'b0;

		in_valid <= 1'b0;
		while (merges_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		$display("%0d words sent under %0d register settings", words_sent, settings_used);
		$display("depths 1 to 8 and odd depth codes, keyed and unkeyed, offsets 0 to 31");
		if (mismatch_count == 0 && merges_pending == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
